// ----- rtl/encoder_position_speed_tracker_assert.svh -----
// assertion macros for the encoder position and speed tracker
`ifndef ENCODER_POSITION_SPEED_TRACKER_ASSERT_SVH
`define ENCODER_POSITION_SPEED_TRACKER_ASSERT_SVH

// same-cycle implication
`define EPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ept_pkg.sv -----
// types, constants and codes shared by the encoder tracker modules
`default_nettype none
package ept_pkg;

  localparam int COUNTER_WIDTH = 16;
  localparam int IN_CNT_W      = 16;
  localparam int TIME_W        = 32;
  localparam int CPR_W         = 16;
  localparam int INTV_W        = 16;
  localparam int TOTAL_W       = 32;
  localparam int ANGLE_W       = 9;
  localparam int RPM_W         = 32;
  localparam int MS_W          = 16;
  localparam int DEG_PER_REV   = 360;
  localparam int MS_PER_MIN    = 60000;

  localparam int DIV_W     = TIME_W + CPR_W;
  localparam int STEP_W    = $clog2(DIV_W + 1);
  localparam int REV_STEPS = TOTAL_W;
  localparam int ANG_STEPS = CPR_W + ANGLE_W;
  localparam int RPM_STEPS = DIV_W;

  localparam int IN_DATA_W     = ((IN_CNT_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = TOTAL_W + TOTAL_W + ANGLE_W + RPM_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CPR_W-1:0]  CPR_RESET  = CPR_W'(1200);
  localparam logic [INTV_W-1:0] INTV_RESET = INTV_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = CFG_IDX_W'(1);

  localparam logic [DIV_W-1:0] RPM_POS_LIM = (DIV_W'(1) << (RPM_W - 1)) - DIV_W'(1);
  localparam logic [DIV_W-1:0] RPM_NEG_LIM = DIV_W'(1) << (RPM_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_REV_GO,
    ST_REV_WAIT,
    ST_ANG_GO,
    ST_ANG_WAIT,
    ST_RPM_GO,
    ST_RPM_WAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_REV,
    DIV_ANG,
    DIV_RPM
  } div_op_t;

  typedef struct packed {
    logic    capture;
    logic    prime;
    logic    commit;
    logic    load_prod;
    logic    div_start;
    div_op_t div_op;
    logic    save_rev;
    logic    save_ang;
    logic    save_rpm;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic primed;
    logic due;
    logic cpr_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/ept_div.sv -----
// shared restoring divider, one quotient bit per cycle
`default_nettype none
`include "encoder_position_speed_tracker_assert.svh"
module ept_div
  import ept_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] count;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W+1:0]  trial;
  logic              borrow;

  assign trial  = {1'b0, rem, quo[DIV_W-1]} - {2'b00, dvs};
  assign borrow = trial[DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= req.steps;
      end else if (busy) begin
        count <= count - STEP_W'(1);
        if (count == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      dvs <= req.den;
    end else if (busy) begin
      if (borrow) begin
        rem <= {rem[DIV_W-2:0], quo[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], 1'b0};
      end else begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

  `EPT_ASSERT_NOW(a_start_idle, req.start, !busy, "divider started while busy")
  `EPT_ASSERT_NOW(a_rem_below, busy, rem < dvs, "partial remainder not below divisor")
  `EPT_ASSERT_NOW(a_done_idle, done, !busy, "done raised while still busy")
  `EPT_ASSERT_NEXT(a_done_pulse, done, !done, "done held for more than one cycle")

endmodule
`default_nettype wire

// ----- rtl/ept_datapath.sv -----
// tracker datapath: config, baselines, total, products, divider and output register
`default_nettype none
module ept_datapath
  import ept_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 status,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  logic [CPR_W-1:0]         cpr;
  logic [INTV_W-1:0]        intv;
  logic                     primed;
  logic [COUNTER_WIDTH-1:0] base_cnt;
  logic [TIME_W-1:0]        base_time;
  logic [TOTAL_W-1:0]       total;
  logic [COUNTER_WIDTH-1:0] in_cnt;
  logic [TIME_W-1:0]        in_time;
  logic [COUNTER_WIDTH-1:0] diff;
  logic [TIME_W-1:0]        elapsed;
  logic                     neg_tot;
  logic                     diff_neg;
  logic [TOTAL_W-1:0]       mag;
  logic [DIV_W-1:0]         num_rpm;
  logic [DIV_W-1:0]         den_rpm;
  logic [TOTAL_W-1:0]       rev;
  logic [ANGLE_W-1:0]       ang;
  logic [RPM_W-1:0]         rpm;
  logic                     out_full;
  logic [TOTAL_W-1:0]       o_total;
  logic [TOTAL_W-1:0]       o_rev;
  logic [ANGLE_W-1:0]       o_ang;
  logic [RPM_W-1:0]         o_rpm;

  logic signed [IN_CNT_W-1:0]      raw_cnt;
  logic signed [COUNTER_WIDTH-1:0] diff_c;
  logic [TIME_W-1:0]               elapsed_c;
  logic [INTV_W-1:0]               intv_eff;
  logic [COUNTER_WIDTH-1:0]        dmag_c;
  logic [COUNTER_WIDTH+MS_W-1:0]   rpm_prod_c;
  logic [DIV_W-1:0]                den_prod_c;
  logic [ANG_STEPS-1:0]            ang_prod_c;
  logic [TOTAL_W-1:0]              q_lo;
  div_req_t                        dreq;
  div_rsp_t                        drsp;

  assign raw_cnt    = s_tdata[IN_CNT_W-1:0];
  assign diff_c     = in_cnt - base_cnt;
  assign elapsed_c  = in_time - base_time;
  assign intv_eff   = (intv == '0) ? INTV_W'(1) : intv;
  assign dmag_c     = diff[COUNTER_WIDTH-1] ? (~diff + COUNTER_WIDTH'(1)) : diff;
  assign rpm_prod_c = dmag_c * MS_W'(MS_PER_MIN);
  assign den_prod_c = cpr * elapsed;
  assign ang_prod_c = drsp.rem[CPR_W-1:0] * ANGLE_W'(DEG_PER_REV);
  assign q_lo       = drsp.quot[TOTAL_W-1:0];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cpr  <= CPR_RESET;
      intv <= INTV_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COUNTS_PER_REV:  cpr  <= cfg_data[CPR_W-1:0];
        REG_REPORT_INTERVAL: intv <= cfg_data[INTV_W-1:0];
        default: ;
      endcase
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      base_cnt  <= '0;
      base_time <= '0;
      total     <= '0;
    end else if (cmd.prime) begin
      primed    <= 1'b1;
      base_cnt  <= in_cnt;
      base_time <= in_time;
    end else if (cmd.commit) begin
      base_cnt  <= in_cnt;
      base_time <= in_time;
      total     <= total + TOTAL_W'(diff_c);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_cnt  <= COUNTER_WIDTH'(raw_cnt);
      in_time <= s_tdata[IN_CNT_W +: TIME_W];
    end
    if (cmd.commit) begin
      diff    <= diff_c;
      elapsed <= elapsed_c;
    end
    if (cmd.load_prod) begin
      neg_tot  <= total[TOTAL_W-1];
      mag      <= total[TOTAL_W-1] ? (~total + TOTAL_W'(1)) : total;
      diff_neg <= diff[COUNTER_WIDTH-1];
      num_rpm  <= DIV_W'(rpm_prod_c);
      den_rpm  <= den_prod_c;
    end
    if (cmd.save_rev) begin
      rev <= neg_tot ? (~q_lo + TOTAL_W'(1)) : q_lo;
    end
    if (cmd.save_ang) begin
      ang <= drsp.quot[ANGLE_W-1:0];
    end
    if (cmd.save_rpm) begin
      if (!diff_neg) begin
        rpm <= (drsp.quot > RPM_POS_LIM) ? RPM_POS_LIM[RPM_W-1:0] : drsp.quot[RPM_W-1:0];
      end else if (drsp.quot > RPM_NEG_LIM) begin
        rpm <= RPM_NEG_LIM[RPM_W-1:0];
      end else begin
        rpm <= ~drsp.quot[RPM_W-1:0] + RPM_W'(1);
      end
    end
  end

  // divider request
  always_comb begin
    dreq.start = cmd.div_start;
    case (cmd.div_op)
      DIV_ANG: begin
        dreq.num   = DIV_W'(ang_prod_c) << (DIV_W - ANG_STEPS);
        dreq.den   = DIV_W'(cpr);
        dreq.steps = STEP_W'(ANG_STEPS);
      end
      DIV_RPM: begin
        dreq.num   = num_rpm;
        dreq.den   = den_rpm;
        dreq.steps = STEP_W'(RPM_STEPS);
      end
      default: begin
        dreq.num   = DIV_W'(mag) << (DIV_W - TOTAL_W);
        dreq.den   = DIV_W'(cpr);
        dreq.steps = STEP_W'(REV_STEPS);
      end
    endcase
  end

  ept_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.out_load) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_total <= total;
      o_rev   <= (cpr == '0) ? '0 : rev;
      o_ang   <= (cpr == '0) ? '0 : ang;
      o_rpm   <= (cpr == '0) ? '0 : rpm;
    end
  end

  assign m_tvalid = out_full;
  assign m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, o_rpm, o_ang, o_rev, o_total};

  assign status.primed   = primed;
  assign status.due      = elapsed_c >= TIME_W'(intv_eff);
  assign status.cpr_zero = (cpr == '0);
  assign status.div_done = drsp.done;
  assign status.out_free = !out_full || m_tready;

endmodule
`default_nettype wire

// ----- rtl/ept_ctrl.sv -----
// tracker controller: sequences capture, update, divisions and result load
`default_nettype none
module ept_ctrl
  import ept_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_op = DIV_REV;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.primed) begin
          cmd.prime  = 1'b1;
          state_next = ST_IDLE;
        end else if (!status.due) begin
          state_next = ST_IDLE;
        end else begin
          cmd.commit = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.load_prod = 1'b1;
        state_next    = status.cpr_zero ? ST_FINISH : ST_REV_GO;
      end
      ST_REV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_REV;
        state_next    = ST_REV_WAIT;
      end
      ST_REV_WAIT: begin
        if (status.div_done) begin
          cmd.save_rev = 1'b1;
          state_next   = ST_ANG_GO;
        end
      end
      ST_ANG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_ANG;
        state_next    = ST_ANG_WAIT;
      end
      ST_ANG_WAIT: begin
        if (status.div_done) begin
          cmd.save_ang = 1'b1;
          state_next   = ST_RPM_GO;
        end
      end
      ST_RPM_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_RPM;
        state_next    = ST_RPM_WAIT;
      end
      ST_RPM_WAIT: begin
        if (status.div_done) begin
          cmd.save_rpm = 1'b1;
          state_next   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/encoder_position_speed_tracker.sv -----
// top level of the encoder position and speed tracker
// a reporting request runs the revolution, angle and speed divisions in turn on the shared
// divider, one bit per cycle (32, 25 and 48 steps); the next request waits for the result load
// counts_per_rev zero skips the divisions; a first or early sample returns to idle, no result
// a held result stalls the input only once the next result is also ready
// synchronous reset restores counts_per_rev 1200 and interval 100 ms and clears the baselines
`default_nettype none
module encoder_position_speed_tracker
  import ept_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // counter_value, time_ms
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,  // position, revolutions, angle_deg, speed_rpm
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  ept_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ept_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire
